FILE: rtl/scbws_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sound-chip bus word sequencer.
package scbws_pkg;

  localparam int WORD_BITS   = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_BITS    = 4;   // up to ten words in one run

  // control word bits
  localparam logic [WORD_BITS-1:0] CW_RESET_LINES = 16'h0300;
  localparam logic [WORD_BITS-1:0] CW_DESELECT    = 16'h4C00;
  localparam logic [WORD_BITS-1:0] CW_SEL_SAA     = 16'h8000;
  localparam logic [WORD_BITS-1:0] CW_ENABLE      = 16'h4000;
  localparam logic [WORD_BITS-1:0] CW_SAVE        = 16'h2000;
  localparam logic [WORD_BITS-1:0] CW_BEEP        = 16'h1000;
  localparam logic [WORD_BITS-1:0] CW_SEL1        = 16'h0800;
  localparam logic [WORD_BITS-1:0] CW_SEL0        = 16'h0400;
  localparam logic [WORD_BITS-1:0] CW_BDIR        = 16'h0200;
  localparam logic [WORD_BITS-1:0] CW_BC1         = 16'h0100;

  localparam logic [7:0] DAC_ADDR_CTRL = 8'h07;
  localparam logic [7:0] DAC_CTRL_VAL  = 8'h80;
  localparam logic [7:0] DAC_ADDR_DATA = 8'h0F;
  localparam logic [7:0] DAC_BIAS_MSB  = 8'd128;
  localparam logic [7:0] DAC_MAX       = 8'd255;
  localparam logic [8:0] NOTHING_LATCHED = 9'h1FF;
  localparam logic [7:0] RAMP_STEP     = 8'd4;

  // register map (word index)
  localparam logic [1:0] REG_BUS_READY  = 2'd0;
  localparam logic [1:0] REG_DAC_ENABLE = 2'd1;
  localparam logic [1:0] REG_RAMP_TEST  = 2'd2;
  localparam logic [1:0] REG_DAC_DECIM  = 2'd3;

  typedef enum logic [2:0] {
    REQ_RESET  = 3'd0,
    REQ_ADDR   = 3'd1,
    REQ_DATA   = 3'd2,
    REQ_SAMPLE = 3'd3,
    REQ_STEP   = 3'd4
  } req_t;

  typedef struct packed {
    logic       bus_ready;
    logic       dac_enable;
    logic       ramp_test;
    logic [4:0] dac_decimation;
  } cfg_t;

  // one queued run: kind, image at its start, low-byte argument, select step
  typedef struct packed {
    req_t                 kind;
    logic [WORD_BITS-1:0] base;
    logic [7:0]           arg;
    logic [1:0]           step;
  } cmd_t;

endpackage

FILE: rtl/scbws_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests, updates the sequencer state and queues up to one run each.
module scbws_front (
  input  logic                clk,
  input  logic                rst_n,
  input  scbws_pkg::cfg_t     cfg,
  input  logic                in_valid,
  input  logic                queue_full,
  input  logic [2:0]          req_type,
  input  logic [7:0]          reg_number,
  input  logic [7:0]          data_byte,
  input  logic signed [15:0]  left_sample,
  input  logic signed [15:0]  right_sample,
  output logic                in_ready,
  output logic                push,
  output scbws_pkg::cmd_t     entry
);

  logic [scbws_pkg::WORD_BITS-1:0] image_r, image_nxt;
  logic [4:0] dcnt_r, dcnt_nxt;
  logic [8:0] last_dac_r, last_dac_nxt;
  logic [7:0] ramp_r, ramp_nxt;
  logic [1:0] step_r, step_nxt;

  logic                            accept;
  logic                            emit;
  scbws_pkg::req_t                 req;
  logic [4:0]                      dnext;
  logic [16:0]                     biased;
  logic [7:0]                      mix_val;
  logic [7:0]                      dac_val;
  logic [1:0]                      step_inc;
  logic [scbws_pkg::WORD_BITS-1:0] chip0_img;
  logic [scbws_pkg::WORD_BITS-1:0] chip1_img;
  logic [scbws_pkg::WORD_BITS-1:0] run_base;
  logic [7:0]                      run_arg;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign req      = scbws_pkg::req_t'(req_type);

  // downmix: sum + 65536 always fits 17 bits, so >>9 never exceeds 255
  assign biased  = 17'({left_sample[15], left_sample} + {right_sample[15], right_sample})
                   + 17'h10000;
  assign mix_val = (biased[16:9] > scbws_pkg::DAC_MAX) ? scbws_pkg::DAC_MAX : biased[16:9];
  assign dnext   = dcnt_r + 5'd1;
  assign step_inc = step_r + 2'd1;

  assign chip0_img = (image_r | scbws_pkg::CW_SEL0) & ~scbws_pkg::CW_SEL1;
  assign chip1_img = ((image_r | scbws_pkg::CW_SEL1) & ~scbws_pkg::CW_SEL0)
                     & ~(scbws_pkg::CW_BDIR | scbws_pkg::CW_BC1);

  always_comb begin
    image_nxt    = image_r;
    dcnt_nxt     = dcnt_r;
    last_dac_nxt = last_dac_r;
    ramp_nxt     = ramp_r;
    step_nxt     = step_r;
    emit         = 1'b0;
    run_base     = image_r;
    run_arg      = 8'd0;
    dac_val      = mix_val;
    if (cfg.bus_ready) begin
      case (req)
        scbws_pkg::REQ_RESET: begin
          emit      = 1'b1;
          image_nxt = image_r | 16'hFF00;
        end
        scbws_pkg::REQ_ADDR: begin
          emit      = 1'b1;
          run_base  = chip0_img;
          run_arg   = {4'd0, reg_number[3:0]};
          image_nxt = chip0_img & ~(scbws_pkg::CW_BDIR | scbws_pkg::CW_BC1);
        end
        scbws_pkg::REQ_DATA: begin
          emit      = 1'b1;
          run_base  = chip0_img;
          run_arg   = data_byte;
          image_nxt = chip0_img & ~scbws_pkg::CW_BDIR;
        end
        scbws_pkg::REQ_SAMPLE: begin
          if (cfg.dac_enable) begin
            if (dnext < cfg.dac_decimation) begin
              dcnt_nxt = dnext;
            end else begin
              dcnt_nxt = 5'd0;
              if (cfg.ramp_test) begin
                ramp_nxt = ramp_r + scbws_pkg::RAMP_STEP;
                dac_val  = ramp_nxt;
              end
              if ({1'b0, dac_val} != last_dac_r) begin
                last_dac_nxt = {1'b0, dac_val};
                emit         = 1'b1;
                run_base     = chip1_img;
                run_arg      = dac_val;
                image_nxt    = chip1_img;
              end
            end
          end
        end
        scbws_pkg::REQ_STEP: begin
          emit      = 1'b1;
          step_nxt  = step_inc;
          image_nxt = (image_r & ~(scbws_pkg::CW_SEL0 | scbws_pkg::CW_SEL1))
                      | (step_inc[0] ? scbws_pkg::CW_SEL0 : '0)
                      | (step_inc[1] ? scbws_pkg::CW_SEL1 : '0);
          run_base  = image_nxt;
        end
        default: begin
        end
      endcase
    end
  end

  assign push       = accept && emit;
  assign entry.kind = req;
  assign entry.base = run_base;
  assign entry.arg  = run_arg;
  assign entry.step = step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_r    <= '0;
      dcnt_r     <= '0;
      last_dac_r <= scbws_pkg::NOTHING_LATCHED;
      ramp_r     <= '0;
      step_r     <= '0;
    end else if (accept) begin
      image_r    <= image_nxt;
      dcnt_r     <= dcnt_nxt;
      last_dac_r <= last_dac_nxt;
      ramp_r     <= ramp_nxt;
      step_r     <= step_nxt;
    end
  end

endmodule

FILE: rtl/scbws_queue.sv
`timescale 1ns / 1ps
// Short run queue between the front end and the word generator.
module scbws_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  scbws_pkg::cmd_t push_cmd,
  input  logic            pop,
  output scbws_pkg::cmd_t head,
  output logic            empty,
  output logic            full
);

  scbws_pkg::cmd_t                   slot_r [scbws_pkg::QUEUE_DEPTH];
  logic [scbws_pkg::QPTR_BITS-1:0]   wr_r, wr_nxt;
  logic [scbws_pkg::QPTR_BITS-1:0]   rd_r, rd_nxt;
  logic [scbws_pkg::QCNT_BITS-1:0]   cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == scbws_pkg::QCNT_BITS'(scbws_pkg::QUEUE_DEPTH));
  assign head  = slot_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop  ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + scbws_pkg::QCNT_BITS'(push) - scbws_pkg::QCNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_cmd;
    end
  end

endmodule

FILE: rtl/scbws_back.sv
`timescale 1ns / 1ps
// Back end: plays queued runs to the output register, one word per cycle unless stalled.
module scbws_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  scbws_pkg::cmd_t                 head,
  input  logic                            q_empty,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [scbws_pkg::WORD_BITS-1:0] out_word,
  output logic                            out_last,
  output logic [1:0]                      out_step
);

  logic                                active_r, active_nxt;
  scbws_pkg::cmd_t                     cmd_r, cmd_nxt;
  logic [scbws_pkg::IDX_BITS-1:0]      idx_r, idx_nxt;
  logic                                valid_r, valid_nxt;
  logic [scbws_pkg::WORD_BITS-1:0]     word_r, word_nxt;
  logic                                last_r, last_nxt;
  logic [1:0]                          step_r, step_nxt;

  scbws_pkg::cmd_t                     cur;
  logic                                have;
  logic                                advance;
  logic [scbws_pkg::IDX_BITS-1:0]      run_len;
  logic [scbws_pkg::WORD_BITS-1:0]     word;
  logic [scbws_pkg::WORD_BITS-1:0]     b;
  logic [scbws_pkg::WORD_BITS-1:0]     a;
  logic                                is_last;

  assign cur     = active_r ? cmd_r : head;
  assign have    = active_r || !q_empty;
  assign advance = !valid_r || out_ready;
  assign pop     = advance && have && !active_r;
  assign b       = cur.base;
  assign a       = {8'd0, cur.arg};

  always_comb begin
    case (cur.kind)
      scbws_pkg::REQ_RESET:  run_len = 4'd4;
      scbws_pkg::REQ_ADDR:   run_len = 4'd2;
      scbws_pkg::REQ_DATA:   run_len = 4'd3;
      scbws_pkg::REQ_SAMPLE: run_len = 4'd10;
      scbws_pkg::REQ_STEP:   run_len = 4'd1;
      default:               run_len = 4'd1;
    endcase
  end

  assign is_last = (idx_r == run_len - 4'd1);

  always_comb begin
    word = b;
    case (cur.kind)
      scbws_pkg::REQ_RESET: begin
        case (idx_r)
          4'd0:    word = b | scbws_pkg::CW_RESET_LINES;
          4'd1:    word = b | scbws_pkg::CW_RESET_LINES | scbws_pkg::CW_DESELECT;
          4'd2:    word = (b | scbws_pkg::CW_RESET_LINES | scbws_pkg::CW_DESELECT)
                          & ~scbws_pkg::CW_ENABLE;
          default: word = b | 16'hFF00;
        endcase
      end
      scbws_pkg::REQ_ADDR: begin
        if (idx_r == 4'd0) begin
          word = b | scbws_pkg::CW_BDIR | scbws_pkg::CW_BC1 | a;
        end else begin
          word = (b & ~(scbws_pkg::CW_BDIR | scbws_pkg::CW_BC1)) | a;
        end
      end
      scbws_pkg::REQ_DATA: begin
        if (idx_r == 4'd1) begin
          word = b | scbws_pkg::CW_BDIR | a;
        end else begin
          word = (b & ~scbws_pkg::CW_BDIR) | a;
        end
      end
      scbws_pkg::REQ_SAMPLE: begin
        // address 7, control 0x80, address 15, then the DAC value
        case (idx_r)
          4'd0: word = b | scbws_pkg::CW_BDIR | scbws_pkg::CW_BC1
                       | {8'd0, scbws_pkg::DAC_ADDR_CTRL};
          4'd1: word = b | {8'd0, scbws_pkg::DAC_ADDR_CTRL};
          4'd2: word = b | {8'd0, scbws_pkg::DAC_CTRL_VAL};
          4'd3: word = b | scbws_pkg::CW_BDIR | {8'd0, scbws_pkg::DAC_CTRL_VAL};
          4'd4: word = b | {8'd0, scbws_pkg::DAC_CTRL_VAL};
          4'd5: word = b | scbws_pkg::CW_BDIR | scbws_pkg::CW_BC1
                       | {8'd0, scbws_pkg::DAC_ADDR_DATA};
          4'd6: word = b | {8'd0, scbws_pkg::DAC_ADDR_DATA};
          4'd8: word = b | scbws_pkg::CW_BDIR | a;
          default: word = b | a;
        endcase
      end
      default: word = b;
    endcase
  end

  always_comb begin
    active_nxt = active_r;
    cmd_nxt    = cmd_r;
    idx_nxt    = idx_r;
    valid_nxt  = valid_r;
    word_nxt   = word_r;
    last_nxt   = last_r;
    step_nxt   = step_r;
    if (advance) begin
      valid_nxt = have;
      if (have) begin
        word_nxt = word;
        last_nxt = is_last;
        step_nxt = cur.step;
        cmd_nxt  = cur;
        if (is_last) begin
          active_nxt = 1'b0;
          idx_nxt    = '0;
        end else begin
          active_nxt = 1'b1;
          idx_nxt    = idx_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
      valid_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    word_r <= word_nxt;
    last_r <= last_nxt;
    step_r <= step_nxt;
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;
  assign out_last  = last_r;
  assign out_step  = step_r;

endmodule

FILE: rtl/sound_chip_bus_word_sequencer_unit.sv
`timescale 1ns / 1ps
// Top level: configuration registers, front end, run queue and word generator.
// First word of a run passes the run queue, then the output register, before it is on out_*.
// Throughput: one control word per cycle while out_tready does not stall it; a run is 1 to 10 words.
// Requests are taken every cycle while the four-entry run queue has room.
// rst_n (synchronous) empties the queue and output, restores register defaults
// and clears the control image, counters and ramp; the DAC value reads as unlatched.
module sound_chip_bus_word_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // reg_number, data_byte, left_sample, right_sample
  input  logic [2:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // control_word, select_step, zero pad
  output logic        out_tlast,  // last_word
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  scbws_pkg::cfg_t  cfg_r;
  scbws_pkg::cmd_t  push_cmd;
  scbws_pkg::cmd_t  head;
  logic             push;
  logic             pop;
  logic             q_empty;
  logic             q_full;
  logic             cfg_wr;
  logic [scbws_pkg::WORD_BITS-1:0] word;
  logic [1:0]       step;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bus_ready      <= 1'b0;
      cfg_r.dac_enable     <= 1'b1;
      cfg_r.ramp_test      <= 1'b0;
      cfg_r.dac_decimation <= 5'd4;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        scbws_pkg::REG_BUS_READY:  cfg_r.bus_ready      <= cfg_pwdata[0];
        scbws_pkg::REG_DAC_ENABLE: cfg_r.dac_enable     <= cfg_pwdata[0];
        scbws_pkg::REG_RAMP_TEST:  cfg_r.ramp_test      <= cfg_pwdata[0];
        scbws_pkg::REG_DAC_DECIM:  cfg_r.dac_decimation <= cfg_pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      scbws_pkg::REG_BUS_READY:  cfg_prdata = {31'd0, cfg_r.bus_ready};
      scbws_pkg::REG_DAC_ENABLE: cfg_prdata = {31'd0, cfg_r.dac_enable};
      scbws_pkg::REG_RAMP_TEST:  cfg_prdata = {31'd0, cfg_r.ramp_test};
      scbws_pkg::REG_DAC_DECIM:  cfg_prdata = {27'd0, cfg_r.dac_decimation};
      default:                   cfg_prdata = '0;
    endcase
  end

  scbws_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_tvalid),
    .queue_full   (q_full),
    .req_type     (in_tuser),
    .reg_number   (in_tdata[7:0]),
    .data_byte    (in_tdata[15:8]),
    .left_sample  (in_tdata[31:16]),
    .right_sample (in_tdata[47:32]),
    .in_ready     (in_tready),
    .push         (push),
    .entry        (push_cmd)
  );

  scbws_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  scbws_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (word),
    .out_last  (out_tlast),
    .out_step  (step)
  );

  assign out_tdata = {6'd0, step, word};

endmodule

FILE: rtl/scbws_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the sequencer, bound to the top level.
module scbws_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_pready
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // a run is played out without gaps
  a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside a run");

  // select step is constant across a run
  a_step_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tdata[17:16] == $past(out_tdata[17:16]))
    else $error("select step changed inside a run");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("config port not ready");

endmodule

bind sound_chip_bus_word_sequencer_unit scbws_checker u_scbws_checker (.*);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sound-chip bus word sequencer unit.
module testbench;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE_GAP  = 30;

  typedef struct {
    logic [2:0]  kind;
    logic [47:0] data;   // reg_number, data_byte, left_sample, right_sample
  } request_t;

  typedef struct {
    logic [15:0] word;
    logic        last;
    logic [1:0]  step;
  } bus_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // reg_number, data_byte, left_sample, right_sample
  logic [2:0]  in_tuser = '0;   // req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // control_word, select_step, zero pad
  logic        out_tlast;       // last_word
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  sound_chip_bus_word_sequencer_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #6 clk = ~clk;

  request_t  request_queue[$];
  bus_word_t bus_word_queue[$];
  logic [15:0] run_words[$];

  // predictor copy of the block's registers and state
  logic        bus_ready_m = 1'b0;
  logic        dac_enable_m = 1'b1;
  logic        ramp_test_m = 1'b0;
  logic [4:0]  decimation_m = 5'd4;
  logic [15:0] image_m = '0;
  logic [4:0]  decim_count_m = '0;
  logic [8:0]  last_dac_m = scbws_pkg::NOTHING_LATCHED;
  logic [7:0]  ramp_m = '0;
  logic [1:0]  sel_step_m = '0;

  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  int rx_wait = 0;
  int send_gap = 0;
  int cycles = 0;
  int failures = 0;
  int requests_taken = 0;
  int words_seen = 0;
  int dac_updates = 0;

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(15, 40);
  endfunction

  function void put_word(logic [7:0] low);
    run_words.push_back(image_m | {8'h00, low});
  endfunction

  function void address_pair(logic [7:0] num);
    image_m = image_m | scbws_pkg::CW_BDIR | scbws_pkg::CW_BC1;
    put_word(num);
    image_m = image_m & ~(scbws_pkg::CW_BDIR | scbws_pkg::CW_BC1);
    put_word(num);
  endfunction

  function void data_triple(logic [7:0] val);
    image_m = image_m & ~scbws_pkg::CW_BDIR;
    put_word(val);
    image_m = image_m | scbws_pkg::CW_BDIR;
    put_word(val);
    image_m = image_m & ~scbws_pkg::CW_BDIR;
    put_word(val);
  endfunction

  // works out the control words one accepted request puts on the bus
  function void sequence_request(logic [2:0] kind, logic [47:0] d);
    logic [4:0] nxt;
    logic [7:0] val;
    int left_s;
    int right_s;
    int mix;
    run_words.delete();
    if (bus_ready_m) begin
      case (kind)
        scbws_pkg::REQ_RESET: begin
          image_m = image_m | scbws_pkg::CW_RESET_LINES;
          put_word(8'h00);
          image_m = image_m | scbws_pkg::CW_DESELECT;
          put_word(8'h00);
          image_m = image_m & ~scbws_pkg::CW_ENABLE;
          put_word(8'h00);
          image_m = image_m | scbws_pkg::CW_ENABLE | scbws_pkg::CW_SEL_SAA | scbws_pkg::CW_SEL0 |
                    scbws_pkg::CW_BEEP | scbws_pkg::CW_SEL1 | scbws_pkg::CW_BDIR |
                    scbws_pkg::CW_BC1 | scbws_pkg::CW_SAVE;
          put_word(8'h00);
        end
        scbws_pkg::REQ_ADDR: begin
          image_m = (image_m | scbws_pkg::CW_SEL0) & ~scbws_pkg::CW_SEL1;
          address_pair({4'h0, d[3:0]});
        end
        scbws_pkg::REQ_DATA: begin
          image_m = (image_m | scbws_pkg::CW_SEL0) & ~scbws_pkg::CW_SEL1;
          data_triple(d[15:8]);
        end
        scbws_pkg::REQ_SAMPLE: begin
          if (dac_enable_m) begin
            nxt = decim_count_m + 5'd1;
            if (nxt < decimation_m) begin
              decim_count_m = nxt;
            end else begin
              decim_count_m = '0;
              if (ramp_test_m) begin
                ramp_m = ramp_m + scbws_pkg::RAMP_STEP;
                val = ramp_m;
              end else begin
                left_s = int'($signed(d[31:16]));
                right_s = int'($signed(d[47:32]));
                mix = (left_s + right_s + 65536) >>> 9;
                val = (mix > 255) ? scbws_pkg::DAC_MAX : mix[7:0];
              end
              if ({1'b0, val} != last_dac_m) begin
                last_dac_m = {1'b0, val};
                image_m = (image_m | scbws_pkg::CW_SEL1) & ~scbws_pkg::CW_SEL0;
                address_pair(scbws_pkg::DAC_ADDR_CTRL);
                data_triple(scbws_pkg::DAC_CTRL_VAL);
                address_pair(scbws_pkg::DAC_ADDR_DATA);
                data_triple(val);
                dac_updates++;
              end
            end
          end
        end
        scbws_pkg::REQ_STEP: begin
          sel_step_m = sel_step_m + 2'd1;
          image_m = image_m & ~(scbws_pkg::CW_SEL0 | scbws_pkg::CW_SEL1);
          if (sel_step_m[0]) image_m = image_m | scbws_pkg::CW_SEL0;
          if (sel_step_m[1]) image_m = image_m | scbws_pkg::CW_SEL1;
          put_word(8'h00);
        end
        default: ;
      endcase
    end
    foreach (run_words[k]) begin
      bus_word_queue.push_back('{word: run_words[k], last: (k == run_words.size() - 1),
                                 step: sel_step_m});
    end
  endfunction

  // input side: one request in flight, refilled from the request queue
  always @(posedge clk) begin : drive
    request_t nxt_req;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        sequence_request(in_tuser, in_tdata);
        requests_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          nxt_req = request_queue.pop_front();
          in_tuser <= nxt_req.kind;
          in_tdata <= nxt_req.data;
          in_tvalid <= 1'b1;
          send_gap = (tx_idle && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure, with one long hold-off on request
  always @(posedge clk) begin : receive
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (rx_idle && $urandom_range(0, 4) == 0) rx_wait <= pick_gap();
    end
  end

  task automatic flag_field(input string field, input logic [31:0] want, input logic [31:0] got);
    failures++;
    if (failures <= 10)
      $display("word %0d: %s expected 0x%0h, got 0x%0h", words_seen, field, want, got);
  endtask

  always @(posedge clk) begin : check
    bus_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      words_seen++;
      if (bus_word_queue.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("word %0d: unexpected word 0x%0h", words_seen, out_tdata);
      end else begin
        want = bus_word_queue.pop_front();
        if (out_tdata[15:0] !== want.word)
          flag_field("control_word", 32'(want.word), 32'(out_tdata[15:0]));
        if (out_tdata[17:16] !== want.step)
          flag_field("select_step", 32'(want.step), 32'(out_tdata[17:16]));
        if (out_tlast !== want.last)
          flag_field("last_word", 32'(want.last), 32'(out_tlast));
        if (out_tdata[23:18] !== '0)
          flag_field("pad", 32'd0, 32'(out_tdata[23:18]));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      scbws_pkg::REG_BUS_READY:  bus_ready_m = val[0];
      scbws_pkg::REG_DAC_ENABLE: dac_enable_m = val[0];
      scbws_pkg::REG_RAMP_TEST:  ramp_test_m = val[0];
      scbws_pkg::REG_DAC_DECIM:  decimation_m = val[4:0];
      default: ;
    endcase
  endtask

  // wait until every request is in and every word is out, then let queued no-ops drain
  task automatic settle();
    while (request_queue.size() > 0 || in_tvalid || bus_word_queue.size() > 0)
      @(negedge clk);
    repeat (SETTLE_GAP) @(negedge clk);
  endtask

  task automatic push_req(input logic [2:0] kind, input logic [7:0] num, input logic [7:0] val,
                          input logic [15:0] left, input logic [15:0] right);
    request_queue.push_back('{kind: kind, data: {right, left, val, num}});
  endtask

  function automatic request_t random_request();
    request_t req;
    logic [15:0] extremes[4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    int r;
    r = $urandom_range(0, 99);
    if (r < 10)      req.kind = scbws_pkg::REQ_RESET;
    else if (r < 28) req.kind = scbws_pkg::REQ_ADDR;
    else if (r < 46) req.kind = scbws_pkg::REQ_DATA;
    else if (r < 84) req.kind = scbws_pkg::REQ_SAMPLE;
    else if (r < 94) req.kind = scbws_pkg::REQ_STEP;
    else             req.kind = scbws_pkg::REQ_STEP + 3'($urandom_range(1, 3));
    req.data[31:0] = $urandom();
    req.data[47:32] = 16'($urandom());
    if (req.kind == scbws_pkg::REQ_SAMPLE) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        req.data[31:16] = extremes[$urandom_range(0, 3)];
        req.data[47:32] = extremes[$urandom_range(0, 3)];
      end else if (r < 45) begin
        // near silence: the DAC value often repeats
        req.data[31:16] = 16'($urandom_range(0, 511)) - 16'd256;
        req.data[47:32] = 16'($urandom_range(0, 511)) - 16'd256;
      end
    end
    return req;
  endfunction

  task automatic run_phase(input bit ready, input bit dac_on, input bit ramp_on,
                           input logic [4:0] decim, input int n, input bit tx_on,
                           input bit rx_on);
    write_reg(scbws_pkg::REG_BUS_READY, 32'(ready));
    write_reg(scbws_pkg::REG_DAC_ENABLE, 32'(dac_on));
    write_reg(scbws_pkg::REG_RAMP_TEST, 32'(ramp_on));
    write_reg(scbws_pkg::REG_DAC_DECIM, 32'(decim));
    tx_idle <= tx_on;
    rx_idle <= rx_on;
    @(negedge clk);
    repeat (n) request_queue.push_back(random_request());
    settle();
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle <= 1'b1;
    rx_idle <= 1'b1;
    @(negedge clk);

    // bus not ready after reset: nothing comes out
    repeat (8) request_queue.push_back(random_request());
    settle();

    // directed part, register defaults otherwise
    write_reg(scbws_pkg::REG_BUS_READY, 32'd1);
    @(negedge clk);
    push_req(scbws_pkg::REQ_RESET, 8'h00, 8'h00, 16'h0000, 16'h0000);
    push_req(scbws_pkg::REQ_ADDR, 8'h00, 8'h00, 16'h0000, 16'h0000);
    push_req(scbws_pkg::REQ_ADDR, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    push_req(scbws_pkg::REQ_DATA, 8'hFF, 8'h00, 16'h0000, 16'h0000);
    push_req(scbws_pkg::REQ_DATA, 8'h00, 8'hFF, 16'hFFFF, 16'hFFFF);
    repeat (4) push_req(scbws_pkg::REQ_STEP, 8'h00, 8'h00, 16'h0000, 16'h0000);
    for (int k = scbws_pkg::REQ_STEP + 1; k < 8; k++)
      push_req(3'(k), 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    repeat (4) push_req(scbws_pkg::REQ_SAMPLE, 8'h00, 8'h00, 16'h8000, 16'h8000);
    repeat (4) push_req(scbws_pkg::REQ_SAMPLE, 8'h00, 8'h00, 16'h7FFF, 16'h7FFF);
    // same value again: no DAC write
    repeat (4) push_req(scbws_pkg::REQ_SAMPLE, 8'h00, 8'h00, 16'h7FFF, 16'h7FFF);
    settle();

    run_phase(1'b1, 1'b1, 1'b0, 5'd1,  80, 1'b1, 1'b1);
    run_phase(1'b1, 1'b1, 1'b1, 5'd1,  60, 1'b0, 1'b0);
    run_phase(1'b1, 1'b1, 1'b1, 5'd0,  50, 1'b1, 1'b1);
    run_phase(1'b1, 1'b1, 1'b0, 5'd31, 40, 1'b1, 1'b0);
    run_phase(1'b1, 1'b1, 1'b0, 5'd16, 40, 1'b0, 1'b1);
    run_phase(1'b1, 1'b0, 1'b0, 5'd2,  50, 1'b1, 1'b1);

    // receiver holds off while the sender keeps going, so the run queue fills
    write_reg(scbws_pkg::REG_DAC_ENABLE, 32'd1);
    write_reg(scbws_pkg::REG_RAMP_TEST, 32'd1);
    write_reg(scbws_pkg::REG_DAC_DECIM, 32'd1);
    tx_idle <= 1'b0;
    rx_idle <= 1'b1;
    hold_req <= 1'b1;
    @(negedge clk);
    repeat (60) request_queue.push_back(random_request());
    settle();

    run_phase(1'b0, 1'b1, 1'b0, 5'd3,  20, 1'b1, 1'b1);
    run_phase(1'b1, 1'b1, 1'b0, 5'd3,  80, 1'b1, 1'b1);

    $display("%0d requests taken, %0d control words checked, %0d DAC writes predicted",
             requests_taken, words_seen, dac_updates);
    $display("decimation 0/1/2/3/4/16/31, ramp and downmix, DAC off, bus not ready, long stall");
    if (failures == 0 && bus_word_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d words still expected", failures, bus_word_queue.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sound_chip_bus_word_sequencer_unit.f
rtl/scbws_pkg.sv
rtl/scbws_front.sv
rtl/scbws_queue.sv
rtl/scbws_back.sv
rtl/sound_chip_bus_word_sequencer_unit.sv
rtl/scbws_checker.sv
tb/sv/testbench.sv
